@@ rtl/core/bbc_pkg.sv @@
// Shared types and constants of the bracket balance checker.
// No dependencies; used by every module under rtl/core except bbc_ram.
package bbc_pkg;

  // Stack geometry
  localparam int MAX_DEPTH = 4096;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int TYPE_W    = 2;

  // Character and counter widths
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 16;
  localparam int CODE_W  = 3;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_MAX_CHARS = 1'b0;
  localparam logic [COUNT_W-1:0] MAX_CHARS_RST = COUNT_W'(4096);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PAREN_O  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_PAREN_C  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_SQUARE_O = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_SQUARE_C = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_CURLY_O  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_CURLY_C  = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_ANGLE_O  = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_ANGLE_C  = 8'h3E;

  // Bracket type codes
  localparam logic [TYPE_W-1:0] TY_PAREN  = 2'd0;
  localparam logic [TYPE_W-1:0] TY_SQUARE = 2'd1;
  localparam logic [TYPE_W-1:0] TY_CURLY  = 2'd2;
  localparam logic [TYPE_W-1:0] TY_ANGLE  = 2'd3;

  // Verdict / line error codes
  localparam logic [CODE_W-1:0] ERR_OK          = 3'd0;
  localparam logic [CODE_W-1:0] ERR_UNCLOSED    = 3'd1;
  localparam logic [CODE_W-1:0] ERR_MISMATCH    = 3'd2;
  localparam logic [CODE_W-1:0] ERR_EXTRA_CLOSE = 3'd3;
  localparam logic [CODE_W-1:0] ERR_TOO_DEEP    = 3'd4;
  localparam logic [CODE_W-1:0] ERR_TOO_LONG    = 3'd5;

  // Classified item passed from front to back
  typedef struct packed {
    logic              is_open;
    logic              is_close;
    logic              is_nl;
    logic [TYPE_W-1:0] code;
    logic              too_long;
  } cls_t;

endpackage

@@ rtl/core/bbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/bbc_front.sv @@
// Front end: accepts characters, classifies them, tracks line length.
// Also holds the max_chars register behind the APB port. Uses bbc_pkg.
module bbc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bbc_pkg::CHAR_W-1:0]    in_char_in,
  // APB port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bbc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bbc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // to queue
  output logic                          q_push,
  output bbc_pkg::cls_t                 q_item,
  input  logic                          q_full
);

  logic [bbc_pkg::COUNT_W-1:0] max_chars_r, max_chars_nxt;
  logic [bbc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [bbc_pkg::COUNT_W:0]   count_inc;
  logic                        reg_sel;
  logic                        accept;

  // APB register access
  assign pready  = 1'b1;
  assign reg_sel = (paddr[bbc_pkg::PADDR_W-1] == bbc_pkg::REG_MAX_CHARS);
  assign prdata  = reg_sel ? bbc_pkg::PDATA_W'(max_chars_r) : '0;

  always_comb begin
    max_chars_nxt = max_chars_r;
    if (psel && penable && pwrite && reg_sel) begin
      max_chars_nxt = pwdata[bbc_pkg::COUNT_W-1:0];
    end
  end

  // Handshake
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Classification
  assign count_inc = {1'b0, count_r} + 1'b1;

  always_comb begin
    q_item          = '0;
    q_item.too_long = (count_inc > {1'b0, max_chars_r});
    q_item.is_nl    = (in_char_in == bbc_pkg::CH_NEWLINE);
    case (in_char_in)
      bbc_pkg::CH_PAREN_O: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::TY_PAREN;
      end
      bbc_pkg::CH_SQUARE_O: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::TY_SQUARE;
      end
      bbc_pkg::CH_CURLY_O: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::TY_CURLY;
      end
      bbc_pkg::CH_ANGLE_O: begin
        q_item.is_open = 1'b1;
        q_item.code    = bbc_pkg::TY_ANGLE;
      end
      bbc_pkg::CH_PAREN_C: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::TY_PAREN;
      end
      bbc_pkg::CH_SQUARE_C: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::TY_SQUARE;
      end
      bbc_pkg::CH_CURLY_C: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::TY_CURLY;
      end
      bbc_pkg::CH_ANGLE_C: begin
        q_item.is_close = 1'b1;
        q_item.code     = bbc_pkg::TY_ANGLE;
      end
      default: begin
      end
    endcase
  end

  // Saturating per-line character count, cleared by newline
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (q_item.is_nl) begin
        count_nxt = '0;
      end else if (count_inc[bbc_pkg::COUNT_W]) begin
        count_nxt = '1;
      end else begin
        count_nxt = count_inc[bbc_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= bbc_pkg::MAX_CHARS_RST;
      count_r     <= '0;
    end else begin
      max_chars_r <= max_chars_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

@@ rtl/core/bbc_queue.sv @@
// Two-entry queue of classified items between front and back.
// Uses bbc_pkg.
module bbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbc_pkg::cls_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output bbc_pkg::cls_t head
);

  bbc_pkg::cls_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/bbc_back.sv @@
// Back end: bracket stack, line error latch and verdict output register.
// Uses bbc_pkg and bbc_ram (stack entries below the top).
module bbc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  // from queue
  input  logic                         q_not_empty,
  input  bbc_pkg::cls_t                q_head,
  output logic                         q_pop,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_balanced,
  output logic [bbc_pkg::CODE_W-1:0]   out_verdict_code
);

  logic [bbc_pkg::DEPTH_W-1:0] depth_r, depth_nxt;
  logic [bbc_pkg::TYPE_W-1:0]  top_r, top_nxt;
  logic [bbc_pkg::TYPE_W-1:0]  byp_data_r;
  logic                        byp_valid_r, byp_valid_nxt;
  logic [bbc_pkg::CODE_W-1:0]  err_r, err_nxt, err_cur;
  logic                        out_valid_r, out_valid_nxt;
  logic [bbc_pkg::CODE_W-1:0]  verdict_r, verdict_nxt;
  logic                        take;
  logic                        do_push, do_pop;
  logic [bbc_pkg::TYPE_W-1:0]  second;
  logic [bbc_pkg::TYPE_W-1:0]  ram_rdata;
  logic [bbc_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic                        ram_we;

  // Take the next item whenever the output register is free or draining
  assign take  = q_not_empty && (!out_valid_r || !out_stall);
  assign q_pop = take;

  // Entry just below the top: bypass after a push, RAM data otherwise
  assign second = byp_valid_r ? byp_data_r : ram_rdata;

  always_comb begin
    depth_nxt     = depth_r;
    top_nxt       = top_r;
    err_nxt       = err_r;
    err_cur       = err_r;
    do_push       = 1'b0;
    do_pop        = 1'b0;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (take) begin
      // line length check comes first
      if (err_cur == bbc_pkg::ERR_OK && q_head.too_long) begin
        err_cur = bbc_pkg::ERR_TOO_LONG;
      end
      err_nxt = err_cur;
      if (err_cur == bbc_pkg::ERR_OK) begin
        if (q_head.is_open) begin
          if (depth_r >= bbc_pkg::DEPTH_W'(bbc_pkg::MAX_DEPTH)) begin
            err_nxt = bbc_pkg::ERR_TOO_DEEP;
          end else begin
            do_push   = 1'b1;
            top_nxt   = q_head.code;
            depth_nxt = depth_r + 1'b1;
          end
        end else if (q_head.is_close) begin
          if (depth_r == '0) begin
            err_nxt = bbc_pkg::ERR_EXTRA_CLOSE;
          end else if (top_r != q_head.code) begin
            err_nxt = bbc_pkg::ERR_MISMATCH;
          end else begin
            do_pop    = 1'b1;
            top_nxt   = second;
            depth_nxt = depth_r - 1'b1;
          end
        end
      end
      // end of line: verdict out, line state cleared
      if (q_head.is_nl) begin
        if (err_nxt == bbc_pkg::ERR_OK && depth_nxt != '0) begin
          verdict_nxt = bbc_pkg::ERR_UNCLOSED;
        end else begin
          verdict_nxt = err_nxt;
        end
        out_valid_nxt = 1'b1;
        depth_nxt     = '0;
        err_nxt       = bbc_pkg::ERR_OK;
      end
    end
  end

  // Stack RAM: old top spills below on push; prefetch the new second entry
  assign ram_we        = do_push && (depth_r != '0);
  assign ram_waddr     = bbc_pkg::ADDR_W'(depth_r - 1'b1);
  assign ram_raddr     = bbc_pkg::ADDR_W'(depth_nxt - 2'd2);
  assign byp_valid_nxt = do_push;

  bbc_ram #(
    .WIDTH (bbc_pkg::TYPE_W),
    .DEPTH (bbc_pkg::MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
    verdict_r  <= verdict_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      err_r       <= bbc_pkg::ERR_OK;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      byp_valid_r <= byp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict_code = verdict_r;
  assign out_balanced     = (verdict_r == bbc_pkg::ERR_OK);

endmodule

@@ rtl/core/bracket_balance_checker.sv @@
// Top level of the bracket balance checker: front, queue and back.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back (and bbc_ram).
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+-------------------------
//   in       | in_valid, in_stall, in_char_in     | one character per item
//   out      | out_valid, out_stall, out_balanced,| one verdict per line
//            | out_verdict_code                   |
//   cfg      | psel, penable, pwrite, paddr,      | max_chars at address 0
//            | pwdata, prdata, pready             |
//
// One character per cycle sustained unless a waiting verdict holds the back; each
// verdict is registered at the output after its newline passes the queue entry, then the back's stack step.
// The top of stack sits in a register; entries below it live in a 4096 x 2
// RAM whose registered read is prefetched one step ahead of every pop.
// Synchronous active-low reset; no clearing pass, the stack RAM needs none.
// A waiting verdict holds the back; the two-entry queue then fills and raises in_stall.
module bracket_balance_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bbc_pkg::CHAR_W-1:0]    in_char_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_balanced,
  output logic [bbc_pkg::CODE_W-1:0]    out_verdict_code,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [bbc_pkg::PDATA_W-1:0]   pwdata,
  output logic [bbc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic          q_push, q_full, q_pop, q_not_empty;
  bbc_pkg::cls_t q_item, q_head;

  bbc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .q_push     (q_push),
    .q_item     (q_item),
    .q_full     (q_full)
  );

  bbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bbc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_balanced     (out_balanced),
    .out_verdict_code (out_verdict_code)
  );

endmodule
